@@ rtl/core/sacl_pkg.sv @@
// Shared types, codes and helpers of the set-associative LRU cache simulator.
package sacl_pkg;

   localparam int unsigned MAX_SETS_DEF  = 256;
   localparam int unsigned MAX_WAYS_DEF  = 8;
   localparam int unsigned TAG_WIDTH_DEF = 32;

   localparam int unsigned SET_BITS_TOP   = 8;
   localparam int unsigned BLOCK_BITS_TOP = 20;
   localparam int unsigned AGE_W          = 32;
   localparam int unsigned TOTAL_W        = 32;
   localparam int unsigned WAY_IDX_W      = 4;
   localparam int unsigned CSR_INDEX_W    = 4;
   localparam int unsigned CSR_DATA_W     = 8;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   typedef logic [CSR_DATA_W-1:0]  csr_data_type;

   localparam csr_index_type CSR_SET_BITS    = 4'd0;
   localparam csr_index_type CSR_BLOCK_BITS  = 4'd1;
   localparam csr_index_type CSR_WAYS_IN_USE = 4'd2;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_STORE  = 2'd1,
      CMD_MODIFY = 2'd2,
      CMD_INSTR  = 2'd3
   } command_type;

   typedef enum logic [1:0] {
      OUT_HIT   = 2'd0,
      OUT_MISS  = 2'd1,
      OUT_EVICT = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_EVAL,
      ST_READ2
   } state_type;

   typedef struct packed {
      command_type command;
      logic [63:0] address;
   } req_payload_type;

   typedef struct packed {
      outcome_type        outcome;
      logic [TOTAL_W-1:0] hit_total;
      logic [TOTAL_W-1:0] miss_total;
      logic [TOTAL_W-1:0] eviction_total;
      logic               last_of_run;
   } rsp_payload_type;

   // Result of the way search: what the access was and which way it lands in.
   typedef struct packed {
      outcome_type          outcome;
      logic [WAY_IDX_W-1:0] way;
   } pick_type;

   function automatic logic [TOTAL_W-1:0] sat_inc(input logic [TOTAL_W-1:0] v);
      sat_inc = (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

@@ rtl/core/sacl_set_ram.sv @@
// Single-port-write, single-port-read set memory with a registered read.
module sacl_set_ram #(
   parameter int unsigned DEPTH  = 256,
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned ADDR_W = 8
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/core/sacl_way_pick.sv @@
// Way search of one set: first free or matching way, else the oldest way.
module sacl_way_pick #(
   parameter int unsigned MAX_WAYS  = 8,
   parameter int unsigned TAG_WIDTH = 32
) (
   input  logic [MAX_WAYS-1:0]                       line_valid,
   input  logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]        line_tag,
   input  logic [MAX_WAYS-1:0][sacl_pkg::AGE_W-1:0]  line_age,
   input  logic [TAG_WIDTH-1:0]                      probe_tag,
   input  logic [4:0]                                ways_eff,
   output sacl_pkg::pick_type                        pick
);
   import sacl_pkg::*;

   localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned LVL   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 0;
   localparam int unsigned NLEAF = 1 << LVL;
   localparam int unsigned NNODE = 2 * NLEAF - 1;

   logic [MAX_WAYS-1:0] in_use;
   logic [MAX_WAYS-1:0] stop;
   logic [AGE_W-1:0]    node_age [NNODE];
   logic [WAY_W-1:0]    node_way [NNODE];
   logic [WAY_W-1:0]    first_way;
   logic                found;

   for (genvar i = 0; i < MAX_WAYS; i++) begin : g_way
      assign in_use[i] = (5'(i) < ways_eff);
      assign stop[i]   = in_use[i] & (~line_valid[i] | (line_tag[i] == probe_tag));
   end

   // Age tree for the victim. Ways out of use sit at the top of the index
   // range and read as the newest possible stamp, so they never win a tie.
   for (genvar i = 0; i < NLEAF; i++) begin : g_leaf
      if (i < MAX_WAYS) begin : g_real
         assign node_age[NLEAF-1+i] = in_use[i] ? line_age[i] : '1;
      end else begin : g_pad
         assign node_age[NLEAF-1+i] = '1;
      end
      assign node_way[NLEAF-1+i] = WAY_W'(i);
   end

   for (genvar k = 0; k + 1 < NLEAF; k++) begin : g_node
      logic take_right;
      assign take_right  = node_age[2*k+2] < node_age[2*k+1];
      assign node_age[k] = take_right ? node_age[2*k+2] : node_age[2*k+1];
      assign node_way[k] = take_right ? node_way[2*k+2] : node_way[2*k+1];
   end

   always_comb begin
      first_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (stop[w]) begin
            first_way = WAY_W'(w);
         end
      end
      found = |stop;
   end

   always_comb begin
      if (!found) begin
         pick.outcome = OUT_EVICT;
         pick.way     = WAY_IDX_W'(node_way[0]);
      end else if (line_valid[first_way]) begin
         pick.outcome = OUT_HIT;
         pick.way     = WAY_IDX_W'(first_way);
      end else begin
         pick.outcome = OUT_MISS;
         pick.way     = WAY_IDX_W'(first_way);
      end
   end

endmodule

@@ rtl/core/set_assoc_cache_lru_sim.sv @@
// Top level of the set-associative cache simulator with LRU replacement.
//
// Each accepted request is one trace access. A load or store is accepted,
// its set row (valid bits, tags and age stamps of all ways) is read from the
// set memory in the same edge, and in the search state, once the output
// register is free, the row is searched, written back and the result is
// placed in the output register. A modify re-reads the row and makes a
// second access with the same sequence number, and gives two result
// transfers, the first with last_of_run low. An instruction access is taken
// and gives no result. No new request is taken until the current access is
// done, since the one read port and one write port of the set memory see
// every access in turn. After reset the block sweeps the set memory, one row
// per cycle, to clear the valid bits; req_stall is high during the sweep.
// Configuration writes are always taken and must only be issued while the
// block is idle. Hit, miss and eviction totals saturate at all ones.
module set_assoc_cache_lru_sim #(
   parameter int unsigned MAX_SETS  = sacl_pkg::MAX_SETS_DEF,
   parameter int unsigned MAX_WAYS  = sacl_pkg::MAX_WAYS_DEF,
   parameter int unsigned TAG_WIDTH = sacl_pkg::TAG_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  sacl_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output sacl_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  sacl_pkg::csr_index_type   csr_index,
   input  sacl_pkg::csr_data_type    csr_wdata
);
   import sacl_pkg::*;

   localparam int unsigned SET_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int unsigned WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int unsigned ROW_W = MAX_WAYS * (1 + TAG_WIDTH + AGE_W);

   // Configuration registers.
   logic [3:0] set_bits_ff, set_bits_in;
   logic [4:0] block_bits_ff, block_bits_in;
   logic [3:0] ways_ff, ways_in;

   logic [3:0] sb_eff;
   logic [4:0] bb_eff;
   logic [4:0] ways_eff;

   // Access state.
   state_type              state_ff, state_in;
   logic [SET_W-1:0]       clr_ff, clr_in;
   logic [SET_W-1:0]       set_ff, set_in;
   logic [TAG_WIDTH-1:0]   tag_ff, tag_in;
   logic                   modify_ff, modify_in;
   logic                   second_ff, second_in;
   logic [AGE_W-1:0]       seq_ff, seq_in;
   logic [TOTAL_W-1:0]     hits_ff, hits_in;
   logic [TOTAL_W-1:0]     misses_ff, misses_in;
   logic [TOTAL_W-1:0]     evicts_ff, evicts_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_payload_type        rsp_data_ff, rsp_data_in;

   // Request decode.
   logic                   req_fire;
   logic                   req_access;
   logic [63:0]            addr_sh;
   logic [63:0]            addr_tag_sh;
   logic [7:0]             idx8;
   logic [8:0]             idx_mask;
   logic [SET_W-1:0]       set_lut [256];
   logic [SET_W-1:0]       set_req;
   logic [TAG_WIDTH-1:0]   tag_req;

   // Set memory and row views.
   logic                   mem_rd_en;
   logic [SET_W-1:0]       mem_rd_addr;
   logic                   mem_wr_en;
   logic [SET_W-1:0]       mem_wr_addr;
   logic [ROW_W-1:0]       mem_wr_data;
   logic [ROW_W-1:0]       mem_rd_data;

   logic [MAX_WAYS-1:0]                 row_valid, new_valid;
   logic [MAX_WAYS-1:0][TAG_WIDTH-1:0]  row_tag, new_tag;
   logic [MAX_WAYS-1:0][AGE_W-1:0]      row_age, new_age;

   pick_type               pick;
   logic [WAY_W-1:0]       pick_way;
   logic                   out_free;
   logic                   eval_done;
   logic                   last_access;

   assign csr_ready = 1'b1;

   // Configuration writes; unknown indexes are dropped.
   always_comb begin
      set_bits_in   = set_bits_ff;
      block_bits_in = block_bits_ff;
      ways_in       = ways_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_SET_BITS:    set_bits_in   = csr_wdata[3:0];
            CSR_BLOCK_BITS:  block_bits_in = csr_wdata[4:0];
            CSR_WAYS_IN_USE: ways_in       = csr_wdata[3:0];
            default: ;
         endcase
      end
   end

   assign sb_eff = (set_bits_ff > 4'(SET_BITS_TOP)) ? 4'(SET_BITS_TOP) : set_bits_ff;
   assign bb_eff = (block_bits_ff > 5'(BLOCK_BITS_TOP)) ? 5'(BLOCK_BITS_TOP) : block_bits_ff;

   always_comb begin
      ways_eff = (ways_ff == 4'd0) ? 5'd1 : {1'b0, ways_ff};
      if (ways_eff > 5'(MAX_WAYS)) begin
         ways_eff = 5'(MAX_WAYS);
      end
   end

   // Address split. The set index is at most eight bits wide and is folded
   // into the memory depth through a constant table.
   assign addr_sh     = req_payload.address >> bb_eff;
   assign addr_tag_sh = req_payload.address >> (bb_eff + 5'(sb_eff));
   assign idx_mask    = (9'd1 << sb_eff) - 9'd1;
   assign idx8        = addr_sh[7:0] & idx_mask[7:0];
   assign tag_req     = addr_tag_sh[TAG_WIDTH-1:0];

   for (genvar i = 0; i < 256; i++) begin : g_set_lut
      localparam int unsigned FOLD = i % MAX_SETS;
      assign set_lut[i] = SET_W'(FOLD);
   end
   assign set_req = set_lut[idx8];

   // Handshakes.
   assign req_stall   = (state_ff != ST_IDLE);
   assign req_fire    = req_valid && !req_stall;
   assign req_access  = req_fire && (req_payload.command != CMD_INSTR);
   assign out_free    = !rsp_valid_ff || !rsp_stall;
   assign eval_done   = (state_ff == ST_EVAL) && out_free;
   assign last_access = !modify_ff || second_ff;

   // Row unpacking and search.
   assign row_valid = mem_rd_data[MAX_WAYS-1:0];
   assign row_tag   = mem_rd_data[MAX_WAYS +: MAX_WAYS*TAG_WIDTH];
   assign row_age   = mem_rd_data[MAX_WAYS + MAX_WAYS*TAG_WIDTH +: MAX_WAYS*AGE_W];

   sacl_way_pick #(
      .MAX_WAYS  (MAX_WAYS),
      .TAG_WIDTH (TAG_WIDTH)
   ) u_way_pick (
      .line_valid (row_valid),
      .line_tag   (row_tag),
      .line_age   (row_age),
      .probe_tag  (tag_ff),
      .ways_eff   (ways_eff),
      .pick       (pick)
   );

   assign pick_way = pick.way[WAY_W-1:0];

   // The chosen way takes the probe tag and the current sequence number.
   always_comb begin
      new_valid           = row_valid;
      new_tag             = row_tag;
      new_age             = row_age;
      new_valid[pick_way] = 1'b1;
      new_tag[pick_way]   = tag_ff;
      new_age[pick_way]   = seq_ff;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_ff == SET_W'(MAX_SETS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_access) begin
               state_in = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (eval_done) begin
               state_in = last_access ? ST_IDLE : ST_READ2;
            end
         end
         ST_READ2: state_in = ST_EVAL;
         default:  state_in = ST_IDLE;
      endcase
   end

   // Memory port controls.
   always_comb begin
      mem_rd_en   = 1'b0;
      mem_rd_addr = set_req;
      mem_wr_en   = 1'b0;
      mem_wr_addr = set_ff;
      mem_wr_data = {new_age, new_tag, new_valid};
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = clr_ff;
            mem_wr_data = '0;
         end
         ST_IDLE: begin
            mem_rd_en = req_access;
         end
         ST_EVAL: begin
            mem_wr_en = out_free;
         end
         ST_READ2: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = set_ff;
         end
         default: ;
      endcase
   end

   // Datapath registers.
   always_comb begin
      clr_in       = clr_ff;
      set_in       = set_ff;
      tag_in       = tag_ff;
      modify_in    = modify_ff;
      second_in    = second_ff;
      seq_in       = seq_ff;
      hits_in      = hits_ff;
      misses_in    = misses_ff;
      evicts_in    = evicts_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (state_ff == ST_CLEAR) begin
         clr_in = clr_ff + 1'b1;
      end

      if (req_access) begin
         set_in    = set_req;
         tag_in    = tag_req;
         modify_in = (req_payload.command == CMD_MODIFY);
         second_in = 1'b0;
      end

      if (eval_done) begin
         case (pick.outcome)
            OUT_HIT: hits_in = sat_inc(hits_ff);
            OUT_MISS: misses_in = sat_inc(misses_ff);
            OUT_EVICT: begin
               misses_in = sat_inc(misses_ff);
               evicts_in = sat_inc(evicts_ff);
            end
            default: ;
         endcase
         rsp_valid_in               = 1'b1;
         rsp_data_in.outcome        = pick.outcome;
         rsp_data_in.hit_total      = hits_in;
         rsp_data_in.miss_total     = misses_in;
         rsp_data_in.eviction_total = evicts_in;
         rsp_data_in.last_of_run    = last_access;
         if (last_access) begin
            seq_in = seq_ff + 1'b1;
         end else begin
            second_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         set_bits_ff   <= '0;
         block_bits_ff <= '0;
         ways_ff       <= 4'd1;
         modify_ff     <= 1'b0;
         second_ff     <= 1'b0;
         seq_ff        <= '0;
         hits_ff       <= '0;
         misses_ff     <= '0;
         evicts_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         set_bits_ff   <= set_bits_in;
         block_bits_ff <= block_bits_in;
         ways_ff       <= ways_in;
         modify_ff     <= modify_in;
         second_ff     <= second_in;
         seq_ff        <= seq_in;
         hits_ff       <= hits_in;
         misses_ff     <= misses_in;
         evicts_ff     <= evicts_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      set_ff      <= set_in;
      tag_ff      <= tag_in;
      rsp_data_ff <= rsp_data_in;
   end

   sacl_set_ram #(
      .DEPTH  (MAX_SETS),
      .WIDTH  (ROW_W),
      .ADDR_W (SET_W)
   ) u_set_ram (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

`ifndef SYNTH
   // The second half of a modify always finds the line the first half left.
   a_modify_second_hits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EVAL) && second_ff |-> (pick.outcome == OUT_HIT))
      else $error("second access of a modify did not hit");

   // The re-read of a set belongs only to the second half of a modify.
   a_read2_in_modify: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ2) |-> (modify_ff && second_ff))
      else $error("set re-read outside a modify");

   // A waiting result that is taken outside the search cycle is not replaced.
   a_rsp_only_from_eval: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_EVAL) && !rsp_stall |=> !rsp_valid_ff)
      else $error("result transfer appeared outside the search cycle");

   // The hit total never moves backward.
   a_hits_monotonic: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) |-> (hits_ff >= $past(hits_ff)))
      else $error("hit total decreased");
`endif

endmodule
